FILE: sv/xfc_pkg.sv
// XMODEM frame checker package: header codes, verdict codes, frame state struct
// and the CRC-16/XMODEM byte update. No dependencies.
package xfc_pkg;

  localparam logic [7:0]  HDR_SOH = 8'h01;
  localparam logic [7:0]  HDR_STX = 8'h02;
  localparam logic [7:0]  HDR_EOT = 8'h04;

  localparam int          POS_W   = 11;
  localparam logic [POS_W-1:0] POS_MAX  = 11'd2047;
  localparam logic [POS_W-1:0] HDR_LEN  = 11'd3;
  localparam logic [POS_W-1:0] LEN_SOH  = 11'd128;
  localparam logic [POS_W-1:0] LEN_STX  = 11'd1024;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef enum logic [1:0] {
    VERD_ERROR  = 2'd0,
    VERD_OK     = 2'd1,
    VERD_FAULT  = 2'd2,
    VERD_FINISH = 2'd3
  } verdict_t;

  // Per-frame state as seen by the judge after the last byte is folded in.
  typedef struct packed {
    logic [7:0]       header;
    logic [7:0]       seq;
    logic [7:0]       seq_cpl;
    logic [7:0]       sum;
    logic [15:0]      crc;
    logic [15:0]      rx_check;
    logic [POS_W-1:0] count;
  } frame_t;

  typedef struct packed {
    verdict_t verdict;
    logic     first;
  } judge_t;

  function automatic logic [POS_W-1:0] data_length(input logic [7:0] hdr);
    logic [POS_W-1:0] len;
    case (hdr)
      HDR_SOH: len = LEN_SOH;
      HDR_STX: len = LEN_STX;
      default: len = '0;
    endcase
    return len;
  endfunction

  // Eight shift steps of the MSB-first CRC, poly 0x1021.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: sv/xfc_judge.sv
// XMODEM frame verdict logic: length, sequence and check tests on a finished frame.
// Depends on xfc_pkg.
module xfc_judge (
  input  xfc_pkg::frame_t frame,
  input  logic [7:0]      expected_seq,
  input  logic            transfer_started,
  input  logic            check_mode,
  output xfc_pkg::judge_t result
);

  logic [xfc_pkg::POS_W-1:0] dlen;
  logic [xfc_pkg::POS_W-1:0] want;
  logic [7:0]                seq_sum;
  logic [7:0]                prev_seq;
  logic                      seq_bad;
  logic                      check_ok;

  assign dlen     = xfc_pkg::data_length(frame.header);
  assign want     = xfc_pkg::HDR_LEN + dlen + (check_mode ? 11'd2 : 11'd1);
  assign seq_sum  = frame.seq + frame.seq_cpl;
  assign prev_seq = expected_seq - 8'd1;
  assign seq_bad  = ((expected_seq == 8'd1) && (frame.seq != 8'd1)) ||
                    ((frame.seq != expected_seq) && (frame.seq != prev_seq));
  assign check_ok = check_mode ? (frame.rx_check == frame.crc)
                               : (frame.rx_check[7:0] == frame.sum);

  always_comb begin
    result.verdict = xfc_pkg::VERD_OK;
    result.first   = 1'b0;
    if (frame.header == xfc_pkg::HDR_EOT) begin
      result.verdict = xfc_pkg::VERD_FINISH;
    end else if (dlen == '0) begin
      result.verdict = xfc_pkg::VERD_ERROR;
    end else if (frame.count != want) begin
      result.verdict = xfc_pkg::VERD_ERROR;
    end else if (seq_sum != 8'hFF) begin
      result.verdict = xfc_pkg::VERD_ERROR;
    end else if (seq_bad) begin
      result.verdict = xfc_pkg::VERD_FAULT;
    end else if (!check_ok) begin
      result.verdict = xfc_pkg::VERD_ERROR;
    end else if (frame.seq != expected_seq) begin
      // repeat of the previous block
      result.verdict = xfc_pkg::VERD_ERROR;
    end else begin
      result.first = !transfer_started && (frame.seq == 8'd1);
    end
  end

endmodule

FILE: sv/xmodem_frame_checker_unit.sv
// XMODEM receive frame checker, top level: input register, frame state,
// result register and APB-style configuration port. Depends on xfc_pkg, xfc_judge.
//
//  channel | handshake               | word
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid / in_ready     | in_data_byte, in_frame_last
//  out     | out_valid / out_ready   | out_payload_valid, out_payload_out,
//          |                         | out_verdict_valid, out_verdict,
//          |                         | out_first_frame, out_frame_seq
//  cfg     | psel, penable, pwrite   | paddr[2:0], pwdata, prdata (check_mode at 0)
//
// One word per cycle sustained while the out channel does not stall; a word passes
// through the input register, then through the CRC/verdict logic into the result
// register. The CRC byte update plus the check compare sets the path.
// Reset (rst_n low, synchronous) clears all frame state, expected sequence = 1,
// check_mode = 1 (CRC). A stalled out channel backs up through the input register
// to in_ready; words that produce no result (header, sequence and check bytes not
// marked last) also wait while a result is held, though they never load the result register.
module xmodem_frame_checker_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_last,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_out,
  output logic        out_verdict_valid,
  output logic [1:0]  out_verdict,
  output logic        out_first_frame,
  output logic [7:0]  out_frame_seq,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_CHECK_MODE = 3'd0;

  // ---------------- configuration ----------------
  logic check_mode_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_mode_r <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CHECK_MODE) begin
      check_mode_r <= pwdata[0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_CHECK_MODE: prdata = {31'd0, check_mode_r};
      default:         prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_last_r;
  logic       fire;        // word in the input register is processed this cycle
  logic       out_valid_r;

  assign fire     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data_byte;
      s1_last_r <= in_frame_last;
    end
  end

  // ---------------- frame state ----------------
  logic [xfc_pkg::POS_W-1:0] pos_r;
  logic [7:0]                header_r, seq_r, seq_cpl_r, sum_r;
  logic [15:0]               crc_r, rx_check_r;
  logic [7:0]                expected_seq_r;
  logic                      transfer_started_r;

  logic [xfc_pkg::POS_W-1:0] data_end;
  logic                      in_payload;
  xfc_pkg::frame_t           frame_nxt;
  xfc_pkg::judge_t           judged;
  logic                      has_result;

  // header is already latched once past the sequence bytes
  assign data_end   = xfc_pkg::HDR_LEN + xfc_pkg::data_length(header_r);
  assign in_payload = (pos_r >= xfc_pkg::HDR_LEN) && (pos_r < data_end);

  always_comb begin
    frame_nxt.header   = (pos_r == 11'd0) ? s1_data_r : header_r;
    frame_nxt.seq      = (pos_r == 11'd1) ? s1_data_r : seq_r;
    frame_nxt.seq_cpl  = (pos_r == 11'd2) ? s1_data_r : seq_cpl_r;
    frame_nxt.sum      = in_payload ? (sum_r + s1_data_r) : sum_r;
    frame_nxt.crc      = in_payload ? xfc_pkg::crc_byte(crc_r, s1_data_r) : crc_r;
    frame_nxt.rx_check = (pos_r >= data_end) ? {rx_check_r[7:0], s1_data_r}
                                             : rx_check_r;
    frame_nxt.count    = (pos_r != xfc_pkg::POS_MAX) ? pos_r + 11'd1 : pos_r;
  end

  xfc_judge u_judge (
    .frame            (frame_nxt),
    .expected_seq     (expected_seq_r),
    .transfer_started (transfer_started_r),
    .check_mode       (check_mode_r),
    .result           (judged)
  );

  assign has_result = in_payload || s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r              <= '0;
      header_r           <= '0;
      seq_r              <= '0;
      seq_cpl_r          <= '0;
      sum_r              <= '0;
      crc_r              <= '0;
      rx_check_r         <= '0;
      expected_seq_r     <= 8'd1;
      transfer_started_r <= 1'b0;
    end else if (fire) begin
      if (s1_last_r) begin
        // frame done: clear per-frame state, advance the transfer on ok, restart it on fault or finish
        pos_r      <= '0;
        header_r   <= '0;
        seq_r      <= '0;
        seq_cpl_r  <= '0;
        sum_r      <= '0;
        crc_r      <= '0;
        rx_check_r <= '0;
        case (judged.verdict) inside
          xfc_pkg::VERD_OK: begin
            expected_seq_r     <= expected_seq_r + 8'd1;
            transfer_started_r <= 1'b1;
          end
          xfc_pkg::VERD_FAULT, xfc_pkg::VERD_FINISH: begin
            expected_seq_r     <= 8'd1;
            transfer_started_r <= 1'b0;
          end
          default: ;
        endcase
      end else begin
        pos_r      <= frame_nxt.count;
        header_r   <= frame_nxt.header;
        seq_r      <= frame_nxt.seq;
        seq_cpl_r  <= frame_nxt.seq_cpl;
        sum_r      <= frame_nxt.sum;
        crc_r      <= frame_nxt.crc;
        rx_check_r <= frame_nxt.rx_check;
      end
    end
  end

  // ---------------- result register ----------------
  logic       pv_r, vv_r, ff_r;
  logic [7:0] po_r, fs_r;
  logic [1:0] vd_r;
  logic       load_out;

  assign load_out = fire && has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pv_r <= in_payload;
      po_r <= in_payload ? s1_data_r : 8'd0;
      vv_r <= s1_last_r;
      vd_r <= s1_last_r ? judged.verdict : xfc_pkg::VERD_ERROR;
      ff_r <= s1_last_r && judged.first;
      fs_r <= s1_last_r ? frame_nxt.seq : 8'd0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_valid = pv_r;
  assign out_payload_out   = po_r;
  assign out_verdict_valid = vv_r;
  assign out_verdict       = vd_r;
  assign out_first_frame   = ff_r;
  assign out_frame_seq     = fs_r;

  // ---------------- assertions ----------------
  // a result always carries a payload byte or a verdict
  a_result_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_payload_valid || out_verdict_valid))
    else $error("result with neither payload nor verdict");

  // first_frame only rides on an ok verdict
  a_first_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_frame) |-> (out_verdict == xfc_pkg::VERD_OK))
    else $error("first_frame without ok verdict");

  // a processed last byte returns the byte position to the header
  a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r) |=> (pos_r == '0))
    else $error("byte position not cleared after frame end");

  // fault or finish restarts the transfer
  a_transfer_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_last_r && (judged.verdict == xfc_pkg::VERD_FAULT ||
                           judged.verdict == xfc_pkg::VERD_FINISH))
    |=> (expected_seq_r == 8'd1 && !transfer_started_r))
    else $error("transfer not restarted after fault or finish");

  // a stalled result is not overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !fire)
    else $error("result register overrun");

endmodule
